### rtl/olid_pkg.sv
// Package for the ordered list block: sizes, operation and status codes,
// sequencer states and the response struct. No dependencies.
package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_DISPLAY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_DELETED   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_FULL      = 3'd4,
    STS_ELEMENT   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DISP,
    S_RESP
  } state_t;

  // One result handed from the sequencer to the output register.
  typedef struct packed {
    logic               vld;
    status_t            status;
    logic [DATA_W-1:0]  element;
    logic               last;
  } rsp_t;

endpackage

### rtl/olid_if.sv
// Request and result channel interfaces (valid/ready) for the ordered list.
// Depends on olid_pkg for the field widths.
interface olid_in_if import olid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface olid_out_if import olid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

### rtl/olid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds when no read is enabled. No dependencies.
module olid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/olid_seq.sv
// Sequencer for the ordered list: entry count, walk pointer, one shared
// comparator and the list operations. Depends on olid_pkg.
module olid_seq import olid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  input  logic [DATA_W-1:0] in_value,
  output logic              in_ready,
  input  logic              slot_free,
  output rsp_t              rsp,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;     // next entry to read
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  status_t           sts_r, sts_nxt;
  logic              more;               // entries left to read
  logic              hit;                // shared comparator

  assign more = (ptr_r < count_r);
  assign hit  = (ram_rdata == value_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    ptr_r    <= ptr_nxt;
    wr_idx_r <= wr_idx_nxt;
    value_r  <= value_nxt;
    sts_r    <= sts_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    wr_idx_nxt  = wr_idx_r;
    value_nxt   = value_r;
    sts_nxt     = sts_r;
    in_ready    = 1'b0;
    rsp         = '0;
    rsp.status  = sts_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_r;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt = in_value;
          ptr_nxt   = CNT_W'(1);
          unique case (in_mode)
            MODE_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                sts_nxt = STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[ADDR_W-1:0];
                ram_wdata = in_value;
                count_nxt = count_r + CNT_W'(1);
                sts_nxt   = STS_INSERTED;
              end
              state_nxt = S_RESP;
            end
            MODE_DELETE, MODE_DISPLAY: begin
              if (count_r == '0) begin
                sts_nxt   = STS_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = (in_mode == MODE_DELETE) ? S_SCAN : S_DISP;
              end
            end
            default: ;  // unused code: dropped
          endcase
        end
      end

      // rdata holds entry ptr_r-1
      S_SCAN: begin
        if (hit) begin
          if (more) begin
            ram_re     = 1'b1;
            ptr_nxt    = ptr_r + CNT_W'(1);
            wr_idx_nxt = ADDR_W'(ptr_r - CNT_W'(1));
            state_nxt  = S_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            sts_nxt   = STS_DELETED;
            state_nxt = S_RESP;
          end
        end else if (more) begin
          ram_re  = 1'b1;
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          sts_nxt   = STS_NOT_FOUND;
          state_nxt = S_RESP;
        end
      end

      // close up: entry ptr_r-1 moves to wr_idx_r
      S_SHIFT: begin
        ram_we     = 1'b1;
        wr_idx_nxt = wr_idx_r + ADDR_W'(1);
        if (more) begin
          ram_re  = 1'b1;
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          sts_nxt   = STS_DELETED;
          state_nxt = S_RESP;
        end
      end

      // rdata holds entry ptr_r-1 until it is sent
      S_DISP: begin
        if (slot_free) begin
          rsp.vld     = 1'b1;
          rsp.status  = STS_ELEMENT;
          rsp.element = ram_rdata;
          rsp.last    = ~more;
          if (more) begin
            ram_re  = 1'b1;
            ptr_nxt = ptr_r + CNT_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          rsp.vld   = 1'b1;
          rsp.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> slot_free)
    else $error("result issued into an occupied output slot");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (CNT_W'(wr_idx_r) + CNT_W'(1) < count_r))
    else $error("shift writes beyond the live entries");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_mode == MODE_INSERT &&
     count_r != CNT_W'(CAPACITY)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

endmodule

### rtl/ordered_list_insert_delete_top.sv
// Top level of the ordered list block: RAM, sequencer and output register.
// Depends on olid_pkg, olid_if, olid_ram and olid_seq.
//
// Keeps up to CAPACITY (16) signed 32-bit values in insertion order in a
// small RAM with one write and one registered read port. A request is taken
// only while the sequencer is idle. Insert writes the entry on acceptance
// and then answers inserted; insert on a full list answers full. Delete
// reads the entries one per cycle from the head with one shared comparator
// until a match, then closes up the later entries at one read and one
// write per cycle; no match answers not found, an empty list answers
// empty. Display streams one entry per cycle from head to tail while the
// output slot is free, marking the tail with last; an empty list gives one
// empty result. Every rate figure is set by the single RAM read port. The
// output register lets a finished result wait for the sink while the
// sequencer goes on; a sink stall holds the sequencer back whenever it has
// its next result ready before the register has drained, which for display
// is every entry.
// Mode 3 is taken and dropped with no result.
module ordered_list_insert_delete_top import olid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  olid_in_if.sink   in_ch,
  olid_out_if.source out_ch
);

  rsp_t              rsp;
  logic              slot_free;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [DATA_W-1:0] out_element_r;
  logic              out_last_r;

  // the slot takes a new result when empty or drained this cycle
  assign slot_free = ~out_valid_r | out_ch.ready;

  olid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  olid_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_value  (in_ch.value),
    .in_ready  (in_ch.ready),
    .slot_free (slot_free),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register: valid under reset, payload loads with each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (rsp.vld) begin
      out_status_r  <= rsp.status;
      out_element_r <= rsp.element;
      out_last_r    <= rsp.last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;

endmodule
